@@ rtl/bmg_pkg.sv @@
`default_nettype none
package bmg_pkg;

    typedef struct packed {
        logic signed [31:0] mean_value;
        logic [30:0]        std_dev;
        logic [15:0]        uniform_a;
        logic [15:0]        uniform_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               from_cache;
        logic               saturated;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       log_step;
        logic       wmul;
        logic       sqrt_step;
        logic       xmul;
        logic       x2mul;
        logic       h_mul;
        logic       h_rec;
        logic       h_fix;
        logic       smul;
        logic       vmul;
        logic       scale;
        logic       finish;
        logic [2:0] term;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cache_valid;
    } status_t;

    localparam int LOG_ROUNDS  = 24;
    localparam int SQRT_ROUNDS = 23;

    localparam logic [30:0] Q30_ONE        = 31'd1073741824;
    localparam logic [32:0] TWO_LN2_Q32    = 33'd5954088944;
    localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;
    localparam logic [45:0] SQRT_TOP_BIT   = 46'd17592186044416; // 2^44

    // Horner term divisors: sine chain first, then cosine chain
    function automatic logic [6:0] term_div(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0:    d = 7'd72;
            3'd1:    d = 7'd42;
            3'd2:    d = 7'd20;
            3'd3:    d = 7'd6;
            3'd4:    d = 7'd56;
            3'd5:    d = 7'd30;
            3'd6:    d = 7'd12;
            default: d = 7'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] term_recip(input logic [2:0] k);
        logic [31:0] r;
        case (k)
            3'd0:    r = 32'd59652323;
            3'd1:    r = 32'd102261126;
            3'd2:    r = 32'd214748364;
            3'd3:    r = 32'd715827882;
            3'd4:    r = 32'd76695844;
            3'd5:    r = 32'd143165576;
            3'd6:    r = 32'd357913941;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bmg_req_if.sv @@
`default_nettype none
interface bmg_req_if;
    logic          valid;
    logic          ready;
    bmg_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/bmg_res_if.sv @@
`default_nettype none
interface bmg_res_if;
    logic          valid;
    logic          ready;
    bmg_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/bmg_ctrl.sv @@
`default_nettype none
module bmg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire bmg_pkg::status_t  status,
    output bmg_pkg::cmd_t          cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOG   = 4'd1;
    localparam logic [3:0] S_WMUL  = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_XMUL  = 4'd4;
    localparam logic [3:0] S_X2    = 4'd5;
    localparam logic [3:0] S_HMUL  = 4'd6;
    localparam logic [3:0] S_HREC  = 4'd7;
    localparam logic [3:0] S_HFIX  = 4'd8;
    localparam logic [3:0] S_SMUL  = 4'd9;
    localparam logic [3:0] S_VMUL  = 4'd10;
    localparam logic [3:0] S_SCALE = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [4:0] LOG_LAST  = 5'(bmg_pkg::LOG_ROUNDS - 1);
    localparam logic [4:0] SQRT_LAST = 5'(bmg_pkg::SQRT_ROUNDS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] term_reg, term_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            term_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.cache_valid ? S_SCALE : S_LOG;
                end
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == LOG_LAST)
                    state_next = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.wmul   = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_XMUL;
            end
            S_XMUL:
            begin
                cmd.xmul   = 1'b1;
                state_next = S_X2;
            end
            S_X2:
            begin
                cmd.x2mul  = 1'b1;
                term_next  = 3'd0;
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.h_mul  = 1'b1;
                state_next = S_HREC;
            end
            S_HREC:
            begin
                cmd.h_rec  = 1'b1;
                state_next = S_HFIX;
            end
            S_HFIX:
            begin
                cmd.h_fix = 1'b1;
                if (term_reg == 3'd3)
                    state_next = S_SMUL;
                else if (term_reg == 3'd7)
                    state_next = S_VMUL;
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = S_HMUL;
                end
            end
            S_SMUL:
            begin
                cmd.smul   = 1'b1;
                term_next  = 3'd4;
                state_next = S_HMUL;
            end
            S_VMUL:
            begin
                cmd.vmul   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/bmg_dpath.sv @@
`default_nettype none
module bmg_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bmg_pkg::cmd_t    cmd,
    input  wire bmg_pkg::req_t    req_data,
    output bmg_pkg::res_t         res_data,
    output bmg_pkg::status_t      status
);

    // cache (control state, reset)
    logic        cache_valid_reg;
    logic [23:0] cache_reg;

    // request operands
    logic signed [31:0] mean_reg;
    logic [30:0]        sd_reg;
    logic               from_cache_reg;

    // log / sqrt
    logic [3:0]  p_reg;
    logic [30:0] m_reg;
    logic [23:0] f_reg;
    logic [45:0] v_reg;
    logic [45:0] root_reg;
    logic [45:0] bit_reg;

    // angle
    logic [2:0]  oct_reg;
    logic [29:0] fp_reg;
    logic [29:0] x_reg;
    logic [29:0] x2_reg;
    logic [30:0] t_reg;
    logic [29:0] y_reg;
    logic [29:0] qe_reg;
    logic [29:0] s_reg;

    // variate and scaling
    logic        z_neg_reg;
    logic [22:0] z_mag_reg;
    logic [33:0] prod_reg;

    bmg_pkg::res_t out_reg;

    // load-time decode
    logic [15:0] a_eff;
    logic [3:0]  p_enc;
    logic [45:0] m_shift;
    logic [29:0] f_oct;
    logic [23:0] cache_mag;

    always_comb
    begin
        a_eff = (req_data.uniform_a == 16'd0) ? 16'd1 : req_data.uniform_a;
        p_enc = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (a_eff[i])
                p_enc = 4'(i);
        end
        m_shift   = {a_eff, 30'd0} >> p_enc;
        f_oct     = {1'b0, req_data.uniform_b[12:0], 16'd0};
        if (req_data.uniform_b[13])
            f_oct = 30'd536870912 - f_oct;
        cache_mag = cache_reg[23] ? (24'd0 - cache_reg) : cache_reg;
    end

    // log2 squaring round
    logic [61:0] sq;
    logic [31:0] sq_hi;
    assign sq    = 62'(m_reg) * 62'(m_reg);
    assign sq_hi = sq[61:30];

    // -2 ln u1 in Q.40
    logic [28:0] tlog;
    logic [61:0] wprod;
    assign tlog  = {5'(5'd16 - {1'b0, p_reg}), 24'd0} - {5'd0, f_reg};
    assign wprod = 62'(tlog) * 62'(bmg_pkg::TWO_LN2_Q32);

    // integer square root step
    logic [45:0] rb;
    assign rb = root_reg + bit_reg;

    // angle products
    logic [59:0] xprod;
    logic [59:0] x2prod;
    logic [60:0] hprod;
    logic [61:0] qprod;
    logic [29:0] qd;
    logic [29:0] rem;
    logic [29:0] q_fix;
    logic [60:0] sprod;
    logic [6:0]  dv;

    assign dv     = bmg_pkg::term_div(cmd.term);
    assign xprod  = 60'(fp_reg) * 60'(bmg_pkg::QUARTER_PI_Q30);
    assign x2prod = 60'(x_reg) * 60'(x_reg);
    assign hprod  = 61'(x2_reg) * 61'(t_reg);
    assign qprod  = 62'(y_reg) * 62'(bmg_pkg::term_recip(cmd.term));
    assign qd     = 30'(qe_reg * 30'(dv));
    assign rem    = y_reg - qd;
    assign q_fix  = (rem >= 30'(dv)) ? qe_reg + 30'd1 : qe_reg;
    assign sprod  = 61'(x_reg) * 61'(t_reg);

    // octant mapping
    logic        swap;
    logic [30:0] cos_mag;
    logic [30:0] sin_mag;
    logic [53:0] zc_prod;
    logic [53:0] zs_prod;
    logic [22:0] zs_mag;

    assign swap    = oct_reg[0] ^ oct_reg[1];
    assign cos_mag = swap ? {1'b0, s_reg} : t_reg;
    assign sin_mag = swap ? t_reg : {1'b0, s_reg};
    assign zc_prod = 54'(root_reg[22:0]) * 54'(cos_mag);
    assign zs_prod = 54'(root_reg[22:0]) * 54'(sin_mag);
    assign zs_mag  = zs_prod[52:30];

    // scaling and saturation
    logic [53:0]        sc_prod;
    logic signed [35:0] val;
    logic signed [35:0] sum;
    logic signed [31:0] sat_val;
    logic               sat_flag;

    assign sc_prod = 54'(z_mag_reg) * 54'(sd_reg);

    always_comb
    begin
        val = z_neg_reg ? -$signed({2'b00, prod_reg}) : $signed({2'b00, prod_reg});
        sum = val + 36'(mean_reg);
        if (sum > 36'sd2147483647)
        begin
            sat_val  = 32'sh7FFFFFFF;
            sat_flag = 1'b1;
        end
        else if (sum < -36'sd2147483648)
        begin
            sat_val  = 32'sh80000000;
            sat_flag = 1'b1;
        end
        else
        begin
            sat_val  = sum[31:0];
            sat_flag = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg <= 1'b0;
            cache_reg       <= '0;
        end
        else if (cmd.load && cache_valid_reg)
        begin
            cache_valid_reg <= 1'b0;
            cache_reg       <= '0;
        end
        else if (cmd.vmul)
        begin
            cache_valid_reg <= 1'b1;
            cache_reg       <= oct_reg[2] ? (24'd0 - {1'b0, zs_mag}) : {1'b0, zs_mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mean_reg       <= req_data.mean_value;
            sd_reg         <= req_data.std_dev;
            from_cache_reg <= cache_valid_reg;
            p_reg          <= p_enc;
            m_reg          <= m_shift[30:0];
            f_reg          <= '0;
            oct_reg        <= req_data.uniform_b[15:13];
            fp_reg         <= f_oct;
            z_neg_reg      <= cache_reg[23];
            z_mag_reg      <= cache_mag[22:0];
        end
        if (cmd.log_step)
        begin
            if (sq_hi[31])
            begin
                m_reg <= sq_hi[31:1];
                f_reg <= {f_reg[22:0], 1'b1};
            end
            else
            begin
                m_reg <= sq_hi[30:0];
                f_reg <= {f_reg[22:0], 1'b0};
            end
        end
        if (cmd.wmul)
        begin
            v_reg    <= wprod[61:16];
            root_reg <= '0;
            bit_reg  <= bmg_pkg::SQRT_TOP_BIT;
        end
        if (cmd.sqrt_step)
        begin
            if (v_reg >= rb)
            begin
                v_reg    <= v_reg - rb;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.xmul)
            x_reg <= xprod[58:29];
        if (cmd.x2mul)
        begin
            x2_reg <= x2prod[59:30];
            t_reg  <= bmg_pkg::Q30_ONE;
        end
        if (cmd.h_mul)
            y_reg <= hprod[59:30];
        if (cmd.h_rec)
            qe_reg <= qprod[61:32];
        if (cmd.h_fix)
            t_reg <= bmg_pkg::Q30_ONE - {1'b0, q_fix};
        if (cmd.smul)
        begin
            s_reg <= sprod[59:30];
            t_reg <= bmg_pkg::Q30_ONE;
        end
        if (cmd.vmul)
        begin
            z_neg_reg <= oct_reg[2] ^ oct_reg[1];
            z_mag_reg <= zc_prod[52:30];
        end
        if (cmd.scale)
            prod_reg <= sc_prod[53:20];
        if (cmd.finish)
        begin
            out_reg.sample     <= sat_val;
            out_reg.from_cache <= from_cache_reg;
            out_reg.saturated  <= sat_flag;
        end
    end

    assign res_data           = out_reg;
    assign status.cache_valid = cache_valid_reg;

endmodule
`default_nettype wire

@@ rtl/box_muller_gaussian_unit.sv @@
`default_nettype none
// Box-Muller normal sample generator, Q16.16 in and out.
// Channels: req (sink) carries mean_value, std_dev, uniform_a, uniform_b;
// res (source) carries sample, from_cache, saturated. A beat moves on
// valid && ready at the rising edge of clk.
// Samples come in pairs: a request with no cached variate computes
// r = sqrt(-2 ln u1), returns the cosine variate and caches the sine one;
// the next request returns the cached variate and ignores its uniforms.
// Order of work for a computed sample: 24 log2 squaring rounds, -2 ln u1,
// 23 square-root rounds, the angle and its square, 8 Horner terms each
// through a multiply, a reciprocal-multiply divide and a fix step, the
// sine product, the variate, the scale, then saturation into the output
// register; a cached sample goes straight to the scale and saturation.
// One request is worked at a time: the next request is taken in the cycle
// after the result is written, and not before the last one is done.
// The result sits in an output register: a new request is taken while it
// waits, but a finished result holds in the datapath until res drains.
// Reset (rst_n, async, low) empties the cache and drops res.valid.
module box_muller_gaussian_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmg_req_if.sink    req,
    bmg_res_if.source  res
);

    bmg_pkg::cmd_t    cmd;
    bmg_pkg::status_t status;

    // sequencer: phase order, round counts, output handshake
    bmg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // log, sqrt, sin/cos, scaling and the variate cache
    bmg_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req.data),
        .res_data (res.data),
        .status   (status)
    );

endmodule
`default_nettype wire
